>>> sv/rtts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtts_pkg
// Shared constants, types and helpers for the round-trip time statistics block.
// ----------------------------------------------------------------------------
package rtts_pkg;

    localparam int RTT_BITS       = 25;
    localparam int MEAN_FRAC_BITS = 8;
    localparam int COUNT_BITS     = 32;
    localparam int DEV_BITS       = 64;

    localparam int MEAN_BITS = RTT_BITS + MEAN_FRAC_BITS;
    localparam int PROD_BITS = 2 * MEAN_BITS;
    localparam int UNIT_BITS = (MEAN_BITS > COUNT_BITS) ? MEAN_BITS : COUNT_BITS;
    localparam int STEP_BITS = $clog2(UNIT_BITS);

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_REPLY  = 2'd1,
        MODE_LOST   = 2'd2,
        MODE_UNUSED = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_DONE
    } state_t;

    typedef enum logic {
        OP_DIV,
        OP_MUL
    } op_t;

    typedef struct packed {
        logic start;
        op_t  op;
    } unit_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_sts_t;

    function automatic logic [COUNT_BITS-1:0] count_up(input logic [COUNT_BITS-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

endpackage
`default_nettype wire

>>> sv/round_trip_time_statistics_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequence: a reply with nonzero time goes through a divide and then a multiply on the
//   shared unit before its result is ready; clear, loss, zero-time reply and the unused
//   mode go straight to the result. One request at a time: in_ready is high only when idle,
//   and a finished result waits until the output register is free or taken on out_ready.
// Reset: asynchronous, active low; statistics return to their cleared values.
// ----------------------------------------------------------------------------
// round_trip_time_statistics_top
// Probe outcome statistics: counters, min/max/last, Welford mean and squared
// deviation sum, with one shared iterative divide/multiply unit.
// ----------------------------------------------------------------------------
module round_trip_time_statistics_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [1:0]                          mode,
    input  wire logic [rtts_pkg::RTT_BITS-1:0]       rtt_us,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic      [rtts_pkg::COUNT_BITS-1:0]     sent_count,
    output logic      [rtts_pkg::COUNT_BITS-1:0]     received_count,
    output logic      [rtts_pkg::COUNT_BITS-1:0]     lost_count,
    output logic      [rtts_pkg::RTT_BITS-1:0]       last_rtt_us,
    output logic      [rtts_pkg::RTT_BITS-1:0]       min_rtt_us,
    output logic      [rtts_pkg::RTT_BITS-1:0]       max_rtt_us,
    output logic      [rtts_pkg::MEAN_BITS-1:0]      mean_rtt_q8,
    output logic      [rtts_pkg::DEV_BITS-1:0]       sq_dev_sum
);

    localparam int CW = rtts_pkg::COUNT_BITS;
    localparam int RW = rtts_pkg::RTT_BITS;
    localparam int MW = rtts_pkg::MEAN_BITS;
    localparam int DW = rtts_pkg::DEV_BITS;
    localparam int UW = rtts_pkg::UNIT_BITS;

    rtts_pkg::state_t state_reg, state_next;

    logic [CW-1:0] sent_reg, sent_next;
    logic [CW-1:0] recv_reg, recv_next;
    logic [CW-1:0] lost_reg, lost_next;
    logic [RW-1:0] min_reg, min_next;
    logic [RW-1:0] max_reg, max_next;
    logic [RW-1:0] last_reg, last_next;
    logic [MW-1:0] mean_reg, mean_next;
    logic [DW-1:0] dev_reg, dev_next;
    logic          neg_reg, neg_next;
    logic [MW-1:0] m1_reg, m1_next;

    logic          out_valid_reg, out_valid_next;
    logic          out_load;
    logic [CW-1:0] sent_out_reg, recv_out_reg, lost_out_reg;
    logic [RW-1:0] last_out_reg, min_out_reg, max_out_reg;
    logic [MW-1:0] mean_out_reg;
    logic [DW-1:0] dev_out_reg;

    rtts_pkg::unit_cmd_t cmd;
    rtts_pkg::unit_sts_t sts;
    logic [UW-1:0]       opa, opb, res_lo, res_hi;

    logic            accept;
    logic [MW-1:0]   x_val;
    logic [CW-1:0]   recv_inc;
    logic [MW-1:0]   q_mag;
    logic [MW-1:0]   m2_val;
    logic [2*UW-1:0] prod;
    logic [DW-1:0]   term;
    logic [DW:0]     dev_sum;

    assign in_ready = (state_reg == rtts_pkg::ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign x_val    = MW'(rtt_us) << rtts_pkg::MEAN_FRAC_BITS;
    assign recv_inc = rtts_pkg::count_up(recv_reg);
    assign q_mag    = res_lo[MW-1:0];
    assign m2_val   = m1_reg - q_mag;
    assign prod     = {res_hi, res_lo};
    assign term     = DW'(prod[rtts_pkg::PROD_BITS-1:2*rtts_pkg::MEAN_FRAC_BITS]);
    assign dev_sum  = {1'b0, dev_reg} + {1'b0, term};
    assign out_load = (state_reg == rtts_pkg::ST_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        sent_next  = sent_reg;
        recv_next  = recv_reg;
        lost_next  = lost_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        last_next  = last_reg;
        mean_next  = mean_reg;
        dev_next   = dev_reg;
        neg_next   = neg_reg;
        m1_next    = m1_reg;
        cmd        = '0;
        opa        = '0;
        opb        = '0;
        unique case (state_reg)
            rtts_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = rtts_pkg::ST_DONE;
                    unique case (rtts_pkg::mode_t'(mode))
                        rtts_pkg::MODE_CLEAR:
                        begin
                            sent_next = '0;
                            recv_next = '0;
                            lost_next = '0;
                            min_next  = '1;
                            max_next  = '0;
                            last_next = '0;
                            mean_next = '0;
                            dev_next  = '0;
                        end
                        rtts_pkg::MODE_REPLY:
                        begin
                            if (rtt_us != '0)
                            begin
                                sent_next = rtts_pkg::count_up(sent_reg);
                                recv_next = recv_inc;
                                last_next = rtt_us;
                                if (rtt_us < min_reg)
                                    min_next = rtt_us;
                                if (rtt_us > max_reg)
                                    max_next = rtt_us;
                                neg_next   = (x_val < mean_reg);
                                m1_next    = neg_next ? (mean_reg - x_val) : (x_val - mean_reg);
                                cmd.start  = 1'b1;
                                cmd.op     = rtts_pkg::OP_DIV;
                                opa        = UW'(m1_next);
                                opb        = UW'(recv_inc);
                                state_next = rtts_pkg::ST_DIV;
                            end
                            else
                            begin
                                sent_next = rtts_pkg::count_up(sent_reg);
                                lost_next = rtts_pkg::count_up(lost_reg);
                                last_next = '0;
                            end
                        end
                        rtts_pkg::MODE_LOST:
                        begin
                            sent_next = rtts_pkg::count_up(sent_reg);
                            lost_next = rtts_pkg::count_up(lost_reg);
                            last_next = '0;
                        end
                        rtts_pkg::MODE_UNUSED:
                        begin
                            state_next = rtts_pkg::ST_DONE;
                        end
                        default:
                        begin
                            state_next = rtts_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            rtts_pkg::ST_DIV:
            begin
                if (sts.done)
                begin
                    // quotient truncated toward zero: step by its magnitude toward x
                    mean_next  = neg_reg ? (mean_reg - q_mag) : (mean_reg + q_mag);
                    cmd.start  = 1'b1;
                    cmd.op     = rtts_pkg::OP_MUL;
                    opa        = UW'(m1_reg);
                    opb        = UW'(m2_val);
                    state_next = rtts_pkg::ST_MUL;
                end
            end
            rtts_pkg::ST_MUL:
            begin
                if (sts.done)
                begin
                    dev_next   = dev_sum[DW] ? '1 : dev_sum[DW-1:0];
                    state_next = rtts_pkg::ST_DONE;
                end
            end
            rtts_pkg::ST_DONE:
            begin
                if (out_load)
                    state_next = rtts_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = rtts_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rtts_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            sent_reg      <= '0;
            recv_reg      <= '0;
            lost_reg      <= '0;
            min_reg       <= '1;
            max_reg       <= '0;
            last_reg      <= '0;
            mean_reg      <= '0;
            dev_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            sent_reg      <= sent_next;
            recv_reg      <= recv_next;
            lost_reg      <= lost_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            last_reg      <= last_next;
            mean_reg      <= mean_next;
            dev_reg       <= dev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        m1_reg  <= m1_next;
        if (out_load)
        begin
            sent_out_reg <= sent_reg;
            recv_out_reg <= recv_reg;
            lost_out_reg <= lost_reg;
            last_out_reg <= last_reg;
            min_out_reg  <= min_reg;
            max_out_reg  <= max_reg;
            mean_out_reg <= mean_reg;
            dev_out_reg  <= dev_reg;
        end
    end

    rtts_mul_div u_mul_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .opa    (opa),
        .opb    (opb),
        .sts    (sts),
        .res_lo (res_lo),
        .res_hi (res_hi)
    );

    assign out_valid      = out_valid_reg;
    assign sent_count     = sent_out_reg;
    assign received_count = recv_out_reg;
    assign lost_count     = lost_out_reg;
    assign last_rtt_us    = last_out_reg;
    assign min_rtt_us     = min_out_reg;
    assign max_rtt_us     = max_out_reg;
    assign mean_rtt_q8    = mean_out_reg;
    assign sq_dev_sum     = dev_out_reg;

    a_unit_done_in_arith: assert property (@(posedge clk) disable iff (!rst_n)
        sts.done |-> (state_reg == rtts_pkg::ST_DIV || state_reg == rtts_pkg::ST_MUL))
        else $error("arith unit finished outside a divide or multiply phase");

    a_sent_balance: assert property (@(posedge clk) disable iff (!rst_n)
        !(&sent_reg) |-> ({1'b0, sent_reg} == {1'b0, recv_reg} + {1'b0, lost_reg}))
        else $error("sent count differs from received plus lost");

    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        (recv_reg != '0) |-> (min_reg <= max_reg))
        else $error("minimum time above maximum time");

    a_empty_run: assert property (@(posedge clk) disable iff (!rst_n)
        (recv_reg == '0) |-> (mean_reg == '0 && dev_reg == '0))
        else $error("mean or deviation sum nonzero with no replies");

endmodule
`default_nettype wire

>>> sv/rtts_mul_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtts_mul_div
// Iterative unsigned divide / multiply, one bit per cycle through one adder.
// Divide: quotient in res_lo. Multiply: product in {res_hi, res_lo}.
// ----------------------------------------------------------------------------
module rtts_mul_div (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire rtts_pkg::unit_cmd_t                cmd,
    input  wire logic [rtts_pkg::UNIT_BITS-1:0]     opa,
    input  wire logic [rtts_pkg::UNIT_BITS-1:0]     opb,
    output rtts_pkg::unit_sts_t                     sts,
    output logic      [rtts_pkg::UNIT_BITS-1:0]     res_lo,
    output logic      [rtts_pkg::UNIT_BITS-1:0]     res_hi
);

    localparam int UW = rtts_pkg::UNIT_BITS;

    logic [UW-1:0]                  a_reg, a_next;
    logic [UW-1:0]                  b_reg, b_next;
    logic [UW-1:0]                  acc_reg, acc_next;
    logic [rtts_pkg::STEP_BITS-1:0] cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    rtts_pkg::op_t                  op_reg, op_next;

    logic [UW+1:0] add_x, add_y, add_s;
    logic          add_sub;

    always_comb
    begin
        add_sub = (op_reg == rtts_pkg::OP_DIV);
        if (add_sub)
        begin
            add_x = {1'b0, acc_reg, a_reg[UW-1]};
            add_y = {2'b00, b_reg};
        end
        else
        begin
            add_x = {2'b00, acc_reg};
            add_y = a_reg[0] ? {2'b00, b_reg} : '0;
        end
        add_s = add_x + (add_sub ? ~add_y : add_y) + {{(UW+1){1'b0}}, add_sub};
    end

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        if (cmd.start)
        begin
            a_next    = opa;
            b_next    = opb;
            acc_next  = '0;
            cnt_next  = rtts_pkg::STEP_BITS'(UW - 1);
            busy_next = 1'b1;
            op_next   = cmd.op;
        end
        else if (busy_reg)
        begin
            if (op_reg == rtts_pkg::OP_DIV)
            begin
                // restoring step: keep the difference when it did not borrow
                acc_next = add_s[UW+1] ? {acc_reg[UW-2:0], a_reg[UW-1]} : add_s[UW-1:0];
                a_next   = {a_reg[UW-2:0], ~add_s[UW+1]};
            end
            else
            begin
                acc_next = add_s[UW:1];
                a_next   = {add_s[0], a_reg[UW-1:1]};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= rtts_pkg::OP_DIV;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign res_lo   = a_reg;
    assign res_hi   = acc_reg;

endmodule
`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the round-trip time statistics block: probe outcome
// requests go in through a bursty driver, a local model of the counters,
// min/max/last, Welford mean and squared-deviation sum predicts every result,
// and a monitor behind a stalling receiver checks each field in order.
// ----------------------------------------------------------------------------
module tb;

    localparam int RTT_BITS       = rtts_pkg::RTT_BITS;
    localparam int MEAN_FRAC_BITS = rtts_pkg::MEAN_FRAC_BITS;
    localparam int COUNT_BITS     = rtts_pkg::COUNT_BITS;
    localparam int DEV_BITS       = rtts_pkg::DEV_BITS;
    localparam int MEAN_BITS      = rtts_pkg::MEAN_BITS;

    localparam int CYCLE_LIMIT = 600000;
    localparam int N_RANDOM    = 1100;
    localparam logic [RTT_BITS-1:0] RTT_MAX = {RTT_BITS{1'b1}};

    typedef struct {
        rtts_pkg::mode_t     op;
        logic [RTT_BITS-1:0] t;
    } probe_req_t;

    typedef struct {
        logic [COUNT_BITS-1:0] sent;
        logic [COUNT_BITS-1:0] received;
        logic [COUNT_BITS-1:0] lost;
        logic [RTT_BITS-1:0]   last;
        logic [RTT_BITS-1:0]   min_t;
        logic [RTT_BITS-1:0]   max_t;
        logic [MEAN_BITS-1:0]  mean;
        logic [DEV_BITS-1:0]   dev;
    } rtt_stats_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic [1:0]            mode      = rtts_pkg::MODE_UNUSED;
    logic [RTT_BITS-1:0]   rtt_us    = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [COUNT_BITS-1:0] sent_count;
    logic [COUNT_BITS-1:0] received_count;
    logic [COUNT_BITS-1:0] lost_count;
    logic [RTT_BITS-1:0]   last_rtt_us;
    logic [RTT_BITS-1:0]   min_rtt_us;
    logic [RTT_BITS-1:0]   max_rtt_us;
    logic [MEAN_BITS-1:0]  mean_rtt_q8;
    logic [DEV_BITS-1:0]   sq_dev_sum;

    probe_req_t pending_probes[$];
    rtt_stats_t expected_stats[$];
    rtt_stats_t stats;
    int         errors      = 0;
    int         cycle_count = 0;
    int         burst_left  = 0;
    int         gap_left    = 0;
    int         stall_pat   = 0;
    int         stall_cnt   = 0;
    int         stall_hold  = 0;

    round_trip_time_statistics_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .rtt_us         (rtt_us),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .sent_count     (sent_count),
        .received_count (received_count),
        .lost_count     (lost_count),
        .last_rtt_us    (last_rtt_us),
        .min_rtt_us     (min_rtt_us),
        .max_rtt_us     (max_rtt_us),
        .mean_rtt_q8    (mean_rtt_q8),
        .sq_dev_sum     (sq_dev_sum)
    );

    always #5 clk = ~clk;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
        return (c == {COUNT_BITS{1'b1}}) ? c : c + 1'b1;
    endfunction

    function automatic rtt_stats_t cleared_stats();
        rtt_stats_t s;
        s.sent     = '0;
        s.received = '0;
        s.lost     = '0;
        s.last     = '0;
        s.min_t    = RTT_MAX;
        s.max_t    = '0;
        s.mean     = '0;
        s.dev      = '0;
        return s;
    endfunction

    // Welford step: mean += (x - mean) / n, dev += (x - old) * (x - new)
    function automatic rtt_stats_t add_reply(input rtt_stats_t s, input logic [RTT_BITS-1:0] t);
        logic [MEAN_BITS-1:0]  x;
        longint                d1;
        longint                d2;
        longint                q;
        logic [63:0]           m1;
        logic [63:0]           m2;
        logic [127:0]          prod;
        logic [127:0]          shifted;
        logic [DEV_BITS-1:0]   term;
        logic [DEV_BITS:0]     acc;
        x          = MEAN_BITS'(t) << MEAN_FRAC_BITS;
        s.sent     = sat_inc(s.sent);
        s.received = sat_inc(s.received);
        s.last     = t;
        if (t < s.min_t)
        begin
            s.min_t = t;
        end
        if (t > s.max_t)
        begin
            s.max_t = t;
        end
        d1      = longint'(x) - longint'(s.mean);
        q       = d1 / longint'(s.received);
        s.mean  = MEAN_BITS'(longint'(s.mean) + q);
        d2      = longint'(x) - longint'(s.mean);
        m1      = (d1 < 0) ? 64'(-d1) : 64'(d1);
        m2      = (d2 < 0) ? 64'(-d2) : 64'(d2);
        prod    = {64'd0, m1} * {64'd0, m2};
        shifted = prod >> (2 * MEAN_FRAC_BITS);
        term    = (|shifted[127:64]) ? {DEV_BITS{1'b1}} : shifted[63:0];
        acc     = {1'b0, s.dev} + {1'b0, term};
        s.dev   = acc[DEV_BITS] ? {DEV_BITS{1'b1}} : acc[DEV_BITS-1:0];
        return s;
    endfunction

    function automatic rtt_stats_t add_loss(input rtt_stats_t s);
        s.sent = sat_inc(s.sent);
        s.lost = sat_inc(s.lost);
        s.last = '0;
        return s;
    endfunction

    task automatic predict_stats(input logic [1:0] m, input logic [RTT_BITS-1:0] t);
        case (rtts_pkg::mode_t'(m))
            rtts_pkg::MODE_CLEAR: stats = cleared_stats();
            rtts_pkg::MODE_REPLY: stats = (t != '0) ? add_reply(stats, t) : add_loss(stats);
            rtts_pkg::MODE_LOST:  stats = add_loss(stats);
            default:    ;
        endcase
        expected_stats.push_back(stats);
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
        end
    endtask

    task automatic queue_probe(input rtts_pkg::mode_t op, input logic [RTT_BITS-1:0] t);
        probe_req_t p;
        p.op = op;
        p.t  = t;
        pending_probes.push_back(p);
    endtask

    function automatic logic [RTT_BITS-1:0] pick_rtt();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0:       return '0;
            1:       return RTT_MAX;
            2:       return RTT_BITS'(1);
            3, 4, 5: return RTT_BITS'($urandom_range(1, 2000));
            6, 7:    return RTT_BITS'($urandom);
            default: return RTT_BITS'($urandom_range(1, 65535));
        endcase
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_stats(mode, rtt_us);
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_probes.size() > 0)
                begin
                    in_valid <= 1'b1;
                    mode     <= pending_probes[0].op;
                    rtt_us   <= pending_probes[0].t;
                    void'(pending_probes.pop_front());
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 30);
                        gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern, reselected whenever the low byte of stall_cnt wraps to zero
    always @(posedge clk)
    begin
        stall_cnt++;
        if (stall_cnt[7:0] == 8'd0)
        begin
            stall_pat = $urandom_range(0, 3);
        end
        case (stall_pat)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= (stall_cnt % 5) != 0;
            default:
            begin
                if (stall_hold > 0)
                begin
                    stall_hold--;
                    out_ready <= 1'b0;
                end
                else
                begin
                    out_ready  <= 1'b1;
                    stall_hold = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
                end
            end
        endcase
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_stats.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, got sent %0d", $time,
                         sent_count);
            end
            else
            begin
                check_field("sent_count", 64'(expected_stats[0].sent), 64'(sent_count));
                check_field("received_count", 64'(expected_stats[0].received),
                            64'(received_count));
                check_field("lost_count", 64'(expected_stats[0].lost), 64'(lost_count));
                check_field("last_rtt_us", 64'(expected_stats[0].last), 64'(last_rtt_us));
                check_field("min_rtt_us", 64'(expected_stats[0].min_t), 64'(min_rtt_us));
                check_field("max_rtt_us", 64'(expected_stats[0].max_t), 64'(max_rtt_us));
                check_field("mean_rtt_q8", 64'(expected_stats[0].mean), 64'(mean_rtt_q8));
                check_field("sq_dev_sum", expected_stats[0].dev, sq_dev_sum);
                void'(expected_stats.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d requests pending, %0d results outstanding",
                     $time, pending_probes.size(), expected_stats.size());
            $display("** round_trip_time_statistics_top: FAILED **");
            $finish;
        end
    end

    initial
    begin
        int sel;
        stats = cleared_stats();

        // directed: reset state, extremes, zero-time reply, ignored mode, clears
        queue_probe(rtts_pkg::MODE_UNUSED, '0);
        queue_probe(rtts_pkg::MODE_REPLY, RTT_MAX);
        queue_probe(rtts_pkg::MODE_REPLY, RTT_BITS'(1));
        queue_probe(rtts_pkg::MODE_REPLY, RTT_MAX);
        queue_probe(rtts_pkg::MODE_REPLY, RTT_BITS'(1));
        queue_probe(rtts_pkg::MODE_REPLY, '0);
        queue_probe(rtts_pkg::MODE_LOST, RTT_MAX);
        queue_probe(rtts_pkg::MODE_UNUSED, RTT_BITS'(1234));
        queue_probe(rtts_pkg::MODE_REPLY, RTT_MAX);
        queue_probe(rtts_pkg::MODE_UNUSED, RTT_MAX);
        queue_probe(rtts_pkg::MODE_CLEAR, RTT_MAX);
        queue_probe(rtts_pkg::MODE_UNUSED, '0);
        queue_probe(rtts_pkg::MODE_LOST, '0);
        queue_probe(rtts_pkg::MODE_REPLY, RTT_BITS'(1));
        queue_probe(rtts_pkg::MODE_REPLY, RTT_BITS'(1));
        queue_probe(rtts_pkg::MODE_REPLY, RTT_MAX);
        queue_probe(rtts_pkg::MODE_REPLY, RTT_BITS'(2));
        queue_probe(rtts_pkg::MODE_CLEAR, '0);
        queue_probe(rtts_pkg::MODE_REPLY, RTT_BITS'(500));
        queue_probe(rtts_pkg::MODE_REPLY, RTT_BITS'(500));
        queue_probe(rtts_pkg::MODE_REPLY, RTT_BITS'(501));
        queue_probe(rtts_pkg::MODE_REPLY, RTT_BITS'(499));
        queue_probe(rtts_pkg::MODE_CLEAR, 25'h0AAAAAA);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 2)
            begin
                queue_probe(rtts_pkg::MODE_CLEAR, RTT_BITS'($urandom));
            end
            else if (sel < 8)
            begin
                queue_probe(rtts_pkg::MODE_UNUSED, RTT_BITS'($urandom));
            end
            else if (sel < 20)
            begin
                queue_probe(rtts_pkg::MODE_LOST, RTT_BITS'($urandom));
            end
            else
            begin
                queue_probe(rtts_pkg::MODE_REPLY, pick_rtt());
            end
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_probes.size() != 0 || in_valid)
        begin
            @(posedge clk);
        end
        while (expected_stats.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (80) @(posedge clk);

        if (errors == 0 && expected_stats.size() == 0)
        begin
            $display("** round_trip_time_statistics_top: PASSED **");
        end
        else
        begin
            $display("** round_trip_time_statistics_top: FAILED **");
        end
        $finish;
    end

endmodule
